>>> hw/rtl/kmcc_pkg.sv
package kmcc_pkg;

    localparam int NumCells = 16;
    localparam int IdxW = 4;
    localparam int CntCfgW = 5;
    localparam int ColorW = 8;
    localparam int SumW = 28;
    localparam int CountW = 21;
    localparam int DistW = 18;
    localparam int DivStepsW = 5;
    localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
    localparam logic [CntCfgW-1:0] ResetClusters = 5'd8;

    typedef enum logic [1:0] {
        REQ_CLASSIFY = 2'd0,
        REQ_LOAD     = 2'd1,
        REQ_READ     = 2'd2,
        REQ_SPARE    = 2'd3
    } req_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic             search;    // compare this cell against the passing pixel
        logic             accum;     // add pixel into the winning cell
        logic             load;      // write centroid
        logic             div_start; // latch sums into divider and clear accumulators
        logic             div_step;  // one restoring-division step
        logic             div_done;  // write mean back to centroid
        logic [IdxW-1:0]  slot;
        logic [IdxW-1:0]  active_last;
    } cell_ctl_t;

    typedef struct packed {
        logic              valid;
        logic [DistW-1:0]  dist_val;
        logic [IdxW-1:0]   idx;
        logic [ColorW-1:0] red;
        logic [ColorW-1:0] green;
        logic [ColorW-1:0] blue;
    } best_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_ACCUM,
        ST_DIV,
        ST_OUT
    } state_t;

    function automatic logic [DistW-1:0] dsq(input logic [ColorW-1:0] a,
                                             input logic [ColorW-1:0] b);
        logic [ColorW-1:0] d;
        logic [2*ColorW-1:0] p;
        d = (a > b) ? a - b : b - a;
        p = d * d;
        return {{(DistW-2*ColorW){1'b0}}, p};
    endfunction

endpackage

>>> hw/rtl/kmeans_color_cluster_pass.sv
// classify: the pixel sweeps the 16-cell compare chain, then the winner is accumulated,
//   then the result stage; load and read go straight to the result stage
// a classify marked last adds per-cell restoring division before the result stage
// one request at a time: the next is taken in the cycle after the result is accepted;
//   result stalls (m_tready low) delay the next request
// aresetn (synchronous, active low) zeroes centroids and accumulators, cluster_count to 8
module kmeans_color_cluster_pass (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], centroid_index[27:24]
    input  logic        s_tlast,   // last_pixel
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cluster[3:0], red_out[11:4], green_out[19:12], blue_out[27:20]
    output logic        m_tlast,   // pass_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import kmcc_pkg::*;

    state_t state_reg, state_next;
    logic [CntCfgW-1:0] ccount_reg;
    logic [IdxW-1:0]   active_last;
    logic [DivStepsW-1:0] cnt_reg, cnt_next;
    req_t              req_reg;
    logic [IdxW-1:0]   slot_reg;
    logic [ColorW-1:0] r_reg, g_reg, b_reg;
    logic              last_reg;
    logic [IdxW-1:0]   o_idx_reg;
    logic [ColorW-1:0] o_r_reg, o_g_reg, o_b_reg;
    logic              o_end_reg;
    cell_ctl_t         ctl;
    logic              accept;

    logic [ColorW-1:0] pr [NumCells+1];
    logic [ColorW-1:0] pg [NumCells+1];
    logic [ColorW-1:0] pb [NumCells+1];
    best_t             bst [NumCells+1];
    logic [ColorW-1:0] cr [NumCells];
    logic [ColorW-1:0] cg [NumCells];
    logic [ColorW-1:0] cb [NumCells];
    logic [ColorW-1:0] sel_r, sel_g, sel_b;

    assign active_last = (ccount_reg == '0) ? '0 :
                         (ccount_reg > CntCfgW'(NumCells)) ? IdxW'(NumCells - 1) :
                         IdxW'(ccount_reg - 1'b1);

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) begin
                state_next = (req_t'(s_tuser) == REQ_CLASSIFY) ? ST_SWEEP : ST_OUT;
                cnt_next   = '0;
            end
            // the winner leaves the last cell in the cycle after that cell compares
            ST_SWEEP: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DivStepsW'(NumCells)) state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                cnt_next   = '0;
                state_next = last_reg ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DivStepsW'(ColorW + 2)) state_next = ST_OUT;
            end
            ST_OUT: if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl             = '0;
        ctl.slot        = slot_reg;
        ctl.active_last = active_last;
        ctl.search      = (state_reg == ST_SWEEP);
        ctl.accum       = (state_reg == ST_ACCUM);
        ctl.load        = (state_reg == ST_OUT) && m_tready && (req_reg == REQ_LOAD);
        ctl.div_start   = (state_reg == ST_DIV) && (cnt_reg == '0);
        ctl.div_step    = (state_reg == ST_DIV) && (cnt_reg != '0);
        ctl.div_done    = (state_reg == ST_DIV) && (cnt_reg == DivStepsW'(ColorW + 2));
    end

    // pixel enters the chain head only at request time and is held there
    assign pr[0]  = r_reg;
    assign pg[0]  = g_reg;
    assign pb[0]  = b_reg;
    assign bst[0] = '0;

    for (genvar i = 0; i < NumCells; i++) begin : g_cell
        kmcc_cell u_cell (
            .aclk, .aresetn,
            .cell_idx(IdxW'(i)), .ctl,
            .px_red_in(pr[i]), .px_green_in(pg[i]), .px_blue_in(pb[i]),
            .best_in(bst[i]),
            .acc_red(r_reg), .acc_green(g_reg), .acc_blue(b_reg),
            .acc_idx(o_idx_reg),
            .px_red_out(pr[i+1]), .px_green_out(pg[i+1]), .px_blue_out(pb[i+1]),
            .best_out(bst[i+1]),
            .cent_red_out(cr[i]), .cent_green_out(cg[i]), .cent_blue_out(cb[i])
        );
    end

    // addressed centroid for load and read requests
    always_comb begin
        sel_r = cr[slot_reg];
        sel_g = cg[slot_reg];
        sel_b = cb[slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ccount_reg <= ResetClusters;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready) ccount_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg  <= req_t'(s_tuser);
            slot_reg <= s_tdata[27:24];
            r_reg    <= s_tdata[7:0];
            g_reg    <= s_tdata[15:8];
            b_reg    <= s_tdata[23:16];
            last_reg <= s_tlast && (req_t'(s_tuser) == REQ_CLASSIFY);
        end
        if (state_reg == ST_IDLE && accept && req_t'(s_tuser) != REQ_CLASSIFY) begin
            o_end_reg <= 1'b0;
        end
        if (state_reg == ST_SWEEP && cnt_reg == DivStepsW'(NumCells)) begin
            o_idx_reg <= bst[NumCells].idx;
            o_r_reg   <= bst[NumCells].red;
            o_g_reg   <= bst[NumCells].green;
            o_b_reg   <= bst[NumCells].blue;
            o_end_reg <= last_reg;
        end else if (state_reg == ST_IDLE && accept) begin
            o_idx_reg <= s_tdata[27:24];
        end
    end

    logic rd_hold_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) rd_hold_reg <= 1'b0;
        else rd_hold_reg <= accept && (req_t'(s_tuser) != REQ_CLASSIFY);
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = rd_hold_reg || (req_reg != REQ_CLASSIFY)
                    ? {4'd0, sel_b, sel_g, sel_r, slot_reg}
                    : {4'd0, o_b_reg, o_g_reg, o_r_reg, o_idx_reg};
    assign m_tlast  = (req_reg == REQ_CLASSIFY) && o_end_reg;

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input open while result pending");
    a_end_classify: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> req_reg == REQ_CLASSIFY) else $error("pass_end on non-classify");
    a_div_after_accum: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_DIV) |-> $past(state_reg == ST_ACCUM)) else $error("bad div entry");
`endif
endmodule

>>> hw/rtl/kmcc_divider.sv
module kmcc_divider (
    input  logic                       aclk,
    input  logic                       start,
    input  logic                       step,
    input  logic [kmcc_pkg::SumW-1:0]  dividend,
    input  logic [kmcc_pkg::CountW-1:0] divisor,
    output logic [kmcc_pkg::ColorW-1:0] mean
);
    import kmcc_pkg::*;

    // restoring division, nine quotient bits are enough; means above 255 clamp to 255
    logic [SumW-1:0]   rem_reg, rem_next;
    logic [CountW-1:0] dvs_reg, dvs_next;
    logic [ColorW:0]   q_reg, q_next;
    logic              ovf_reg, ovf_next;
    logic [DivStepsW-1:0] n_reg, n_next;
    logic [SumW+ColorW:0] shifted;
    logic [SumW+ColorW:0] trial;

    always_comb begin
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        q_next   = q_reg;
        ovf_next = ovf_reg;
        n_next   = n_reg;
        shifted  = {{(SumW+ColorW+1-CountW){1'b0}}, dvs_reg} << (ColorW - n_reg);
        trial    = {{(ColorW+1){1'b0}}, rem_reg};
        if (start) begin
            rem_next = dividend;
            dvs_next = (divisor == '0) ? CountW'(1) : divisor;
            q_next   = '0;
            n_next   = '0;
            // quotient >= 512 means dividend >= divisor << 9
            ovf_next = ({{(ColorW+1){1'b0}}, dividend} >=
                        ({{(SumW+ColorW+1-CountW){1'b0}},
                          ((divisor == '0) ? CountW'(1) : divisor)} << (ColorW + 1)));
        end else if (step && n_reg <= DivStepsW'(ColorW)) begin
            if (trial >= shifted) begin
                rem_next = SumW'(trial - shifted);
                q_next   = {q_reg[ColorW-1:0], 1'b1};
            end else begin
                q_next   = {q_reg[ColorW-1:0], 1'b0};
            end
            n_next = n_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
        n_reg   <= n_next;
    end

    assign mean = (ovf_reg || q_reg[ColorW]) ? {ColorW{1'b1}} : q_reg[ColorW-1:0];
endmodule

>>> hw/rtl/kmcc_cell.sv
module kmcc_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [kmcc_pkg::IdxW-1:0]    cell_idx,
    input  kmcc_pkg::cell_ctl_t          ctl,
    input  logic [kmcc_pkg::ColorW-1:0]  px_red_in,
    input  logic [kmcc_pkg::ColorW-1:0]  px_green_in,
    input  logic [kmcc_pkg::ColorW-1:0]  px_blue_in,
    input  kmcc_pkg::best_t              best_in,
    input  logic [kmcc_pkg::ColorW-1:0]  acc_red,
    input  logic [kmcc_pkg::ColorW-1:0]  acc_green,
    input  logic [kmcc_pkg::ColorW-1:0]  acc_blue,
    input  logic [kmcc_pkg::IdxW-1:0]    acc_idx,
    output logic [kmcc_pkg::ColorW-1:0]  px_red_out,
    output logic [kmcc_pkg::ColorW-1:0]  px_green_out,
    output logic [kmcc_pkg::ColorW-1:0]  px_blue_out,
    output kmcc_pkg::best_t              best_out,
    output logic [kmcc_pkg::ColorW-1:0]  cent_red_out,
    output logic [kmcc_pkg::ColorW-1:0]  cent_green_out,
    output logic [kmcc_pkg::ColorW-1:0]  cent_blue_out
);
    import kmcc_pkg::*;

    logic [ColorW-1:0] cr_reg, cg_reg, cb_reg;
    logic [SumW-1:0]   rs_reg, gs_reg, bs_reg;
    logic [CountW-1:0] cnt_reg;
    logic [ColorW-1:0] pr_reg, pg_reg, pb_reg;
    best_t             best_reg, best_next;
    logic [DistW-1:0]  d;
    logic              in_use, hit;
    logic [ColorW-1:0] mr, mg, mb;
    logic [SumW:0]     rs_add, gs_add, bs_add;
    logic [CountW:0]   cnt_add;

    assign in_use = (cell_idx <= ctl.active_last);
    assign hit    = ctl.accum && (acc_idx == cell_idx);
    assign d = dsq(px_red_in, cr_reg) + dsq(px_green_in, cg_reg) + dsq(px_blue_in, cb_reg);

    always_comb begin
        best_next = best_in;
        if (ctl.search && in_use && (!best_in.valid || d < best_in.dist_val)) begin
            best_next.valid    = 1'b1;
            best_next.dist_val = d;
            best_next.idx      = cell_idx;
            best_next.red      = cr_reg;
            best_next.green    = cg_reg;
            best_next.blue     = cb_reg;
        end
    end

    assign rs_add  = {1'b0, rs_reg} + {{(SumW+1-ColorW){1'b0}}, acc_red};
    assign gs_add  = {1'b0, gs_reg} + {{(SumW+1-ColorW){1'b0}}, acc_green};
    assign bs_add  = {1'b0, bs_reg} + {{(SumW+1-ColorW){1'b0}}, acc_blue};
    assign cnt_add = {1'b0, cnt_reg} + (CountW+1)'(1);

    kmcc_divider u_div_r (.aclk, .start(ctl.div_start), .step(ctl.div_step),
                          .dividend(rs_reg), .divisor(cnt_reg), .mean(mr));
    kmcc_divider u_div_g (.aclk, .start(ctl.div_start), .step(ctl.div_step),
                          .dividend(gs_reg), .divisor(cnt_reg), .mean(mg));
    kmcc_divider u_div_b (.aclk, .start(ctl.div_start), .step(ctl.div_step),
                          .dividend(bs_reg), .divisor(cnt_reg), .mean(mb));

    always_ff @(posedge aclk) begin
        pr_reg   <= px_red_in;
        pg_reg   <= px_green_in;
        pb_reg   <= px_blue_in;
        best_reg <= best_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cr_reg  <= '0;
            cg_reg  <= '0;
            cb_reg  <= '0;
            rs_reg  <= '0;
            gs_reg  <= '0;
            bs_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            // load color comes straight from the request register, not the delayed chain
            if (ctl.load && ctl.slot == cell_idx) begin
                cr_reg <= acc_red;
                cg_reg <= acc_green;
                cb_reg <= acc_blue;
            end else if (ctl.div_done && in_use) begin
                cr_reg <= mr;
                cg_reg <= mg;
                cb_reg <= mb;
            end
            if (ctl.div_start) begin
                rs_reg  <= '0;
                gs_reg  <= '0;
                bs_reg  <= '0;
                cnt_reg <= '0;
            end else if (hit) begin
                rs_reg  <= rs_add[SumW]  ? SumMax   : rs_add[SumW-1:0];
                gs_reg  <= gs_add[SumW]  ? SumMax   : gs_add[SumW-1:0];
                bs_reg  <= bs_add[SumW]  ? SumMax   : bs_add[SumW-1:0];
                cnt_reg <= cnt_add[CountW] ? CountMax : cnt_add[CountW-1:0];
            end
        end
    end

    assign px_red_out     = pr_reg;
    assign px_green_out   = pg_reg;
    assign px_blue_out    = pb_reg;
    assign best_out       = best_reg;
    assign cent_red_out   = cr_reg;
    assign cent_green_out = cg_reg;
    assign cent_blue_out  = cb_reg;
endmodule
